@@ hdl/su_pkg.sv @@
// ----------------------------------------------------------------------------
// su_pkg: shared types and constants of the scanline unfilter
// Filter type codes, register indexes, field widths and the tag that
// travels with each data byte from the control unit to the datapath.
// ----------------------------------------------------------------------------
package su_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int COL_W           = $clog2(MAX_ROW_BYTES);
    localparam int WIN_IDX_W       = $clog2(MAX_PIXEL_BYTES);
    localparam int BPP_W           = 4;
    localparam int RB_W            = 14;
    localparam int ROWS_W          = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    // filter type codes as they appear in the stream
    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;

    // per data byte control tag
    typedef struct packed {
        logic [COL_W-1:0] col;
        t_filter          filter;
        logic             first_row;
        logic             row_end;
        logic             image_end;
        logic             err;
    } t_tag;

endpackage

@@ hdl/su_line_store.sv @@
// ----------------------------------------------------------------------------
// su_line_store: previous row buffer
// One write port and one read port with registered read data. The read
// word holds until the next read enable.
// ----------------------------------------------------------------------------
module su_line_store
    import su_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [7:0]       i_wr_data
);

    logic [7:0] r_mem [MAX_ROW_BYTES];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/su_ctrl.sv @@
// ----------------------------------------------------------------------------
// su_ctrl: stream control and configuration registers
// Tracks filter type bytes, column and row counts, the first row and the
// sticky error, and tags each accepted data byte for the datapath.
// ----------------------------------------------------------------------------
module su_ctrl
    import su_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    output logic                  o_data_accept,
    output t_tag                  o_tag,
    output logic [BPP_W-1:0]      o_bpp,
    output logic [WIN_IDX_W-1:0]  o_bpp_idx
);

    logic [BPP_W-1:0]  r_bpp;
    logic [RB_W-1:0]   r_rb;
    logic [ROWS_W-1:0] r_rows;
    logic [COL_W-1:0]  r_col;
    logic [ROWS_W-1:0] r_row;
    t_filter           r_filter;
    logic              r_awaiting;
    logic              r_first;
    logic              r_error;

    logic [BPP_W-1:0]  bpp_eff;
    logic [RB_W-1:0]   rb_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic              row_end;
    logic              image_end;

    // effective register values
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = r_bpp;
        end
        if (r_rb == '0) begin
            rb_eff = RB_W'(1);
        end else if (r_rb > RB_W'(MAX_ROW_BYTES)) begin
            rb_eff = RB_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = r_rb;
        end
        rows_eff = (r_rows == '0) ? ROWS_W'(1) : r_rows;
    end

    assign row_end       = (RB_W'(r_col) + RB_W'(1)) >= rb_eff;
    assign image_end     = row_end
                           && ((17'(r_row) + 17'd1) >= 17'(rows_eff));
    assign o_data_accept = i_accept && !r_awaiting;
    assign o_bpp         = bpp_eff;
    assign o_bpp_idx     = WIN_IDX_W'(bpp_eff - BPP_W'(1));

    // tag for the byte being accepted
    always_comb begin
        o_tag.col       = r_col;
        o_tag.filter    = r_filter;
        o_tag.first_row = r_first;
        o_tag.row_end   = row_end;
        o_tag.image_end = image_end;
        o_tag.err       = r_error;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp  <= BPP_W'(1);
            r_rb   <= RB_W'(1);
            r_rows <= ROWS_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BPP:  r_bpp  <= i_cfg_data[BPP_W-1:0];
                REG_RB:   r_rb   <= i_cfg_data[RB_W-1:0];
                REG_ROWS: r_rows <= i_cfg_data[ROWS_W-1:0];
                default:  ;
            endcase
        end
    end

    // stream position and filter type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_filter   <= FLT_NONE;
            r_awaiting <= 1'b1;
            r_first    <= 1'b1;
            r_error    <= 1'b0;
        end else if (i_accept) begin
            if (r_awaiting) begin
                if (i_byte > 8'(FLT_PAETH)) begin
                    r_error  <= 1'b1;
                    r_filter <= FLT_NONE;
                end else begin
                    r_filter <= t_filter'(i_byte[2:0]);
                end
                r_awaiting <= 1'b0;
            end else if (row_end) begin
                r_col      <= '0;
                r_awaiting <= 1'b1;
                if (image_end) begin
                    r_row   <= '0;
                    r_first <= 1'b1;
                end else begin
                    r_row   <= r_row + ROWS_W'(1);
                    r_first <= 1'b0;
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

endmodule

@@ hdl/su_recon.sv @@
// ----------------------------------------------------------------------------
// su_recon: reconstruction datapath
// Stage register for one data byte, neighbour windows, the None, Sub, Up,
// Average and Paeth predictors, and the output word register.
// ----------------------------------------------------------------------------
module su_recon
    import su_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_tag                 i_tag,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_above,
    input  logic [BPP_W-1:0]     i_bpp,
    input  logic [WIN_IDX_W-1:0] i_bpp_idx,
    input  logic                 i_out_stall,
    output logic                 o_hold,
    output logic                 o_wr_en,
    output logic [COL_W-1:0]     o_wr_addr,
    output logic [7:0]           o_wr_data,
    output logic                 o_valid,
    output logic [7:0]           o_pixel_byte,
    output logic                 o_status,
    output logic                 o_row_end,
    output logic                 o_image_end
);

    logic       r_s1_valid;
    t_tag       r_tag;
    logic [7:0] r_byte;
    logic [7:0] r_left [MAX_PIXEL_BYTES];
    logic [7:0] r_ul   [MAX_PIXEL_BYTES];
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_status;
    logic       r_out_row_end;
    logic       r_out_image_end;

    logic       s1_adv;
    logic       step;
    logic       has_left;
    logic [7:0] above;
    logic [7:0] left;
    logic [7:0] ul;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] recon;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [7:0]        pick;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

    // pipeline flow
    assign s1_adv = !r_out_valid || !i_out_stall;
    assign o_hold = r_s1_valid && !s1_adv;
    assign step   = r_s1_valid && s1_adv;

    // neighbours, zero inside the first pixel and above the first row
    assign above    = r_tag.first_row ? 8'd0 : i_above;
    assign has_left = r_tag.col >= COL_W'(i_bpp);
    assign left     = has_left ? r_left[i_bpp_idx] : 8'd0;
    assign ul       = has_left ? r_ul[i_bpp_idx] : 8'd0;
    assign avg_sum  = {1'b0, left} + {1'b0, above};

    // predictor select
    always_comb begin
        case (r_tag.filter)
            FLT_SUB:   pred = left;
            FLT_UP:    pred = above;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH: pred = paeth_pick(left, above, ul);
            default:   pred = 8'd0;
        endcase
    end

    assign recon = r_byte + pred;

    // line store write back
    assign o_wr_en   = step;
    assign o_wr_addr = r_tag.col;
    assign o_wr_data = recon;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_hold) begin
            r_s1_valid <= i_load;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tag  <= i_tag;
            r_byte <= i_byte;
        end
    end

    // left and upper-left windows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i] <= 8'd0;
                r_ul[i]   <= 8'd0;
            end
        end else if (step) begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                r_left[i] <= r_left[i-1];
                r_ul[i]   <= r_ul[i-1];
            end
            r_left[0] <= recon;
            r_ul[0]   <= above;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte      <= recon;
            r_out_status    <= r_tag.err;
            r_out_row_end   <= r_tag.row_end;
            r_out_image_end <= r_tag.image_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_byte = r_out_byte;
    assign o_status     = r_out_status;
    assign o_row_end    = r_out_row_end;
    assign o_image_end  = r_out_image_end;

endmodule

@@ hdl/scanline_unfilter.sv @@
// Pipeline: data bytes pass the stage register and then the output word register.
// Throughput: one byte per cycle, type bytes included, unless the output stalls;
// one line store read and one write per data byte; Paeth logic is combinational.
// Reset: synchronous, active low; registers return to 1, the stream restarts
// on a filter type byte in the first row. The line store is not cleared.
// ----------------------------------------------------------------------------
// scanline_unfilter: scanline reconstruction of a filtered image stream
// Takes one filtered byte per word, drops the filter type bytes and gives
// one reconstructed byte per data byte with row and image end flags.
// ----------------------------------------------------------------------------
module scanline_unfilter
    import su_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_filtered_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_pixel_byte,
    output logic                  o_status,
    output logic                  o_row_end,
    output logic                  o_image_end
);

    logic                 accept;
    logic                 data_accept;
    logic                 hold;
    t_tag                 tag;
    logic [BPP_W-1:0]     bpp;
    logic [WIN_IDX_W-1:0] bpp_idx;
    logic [7:0]           above;
    logic                 wr_en;
    logic [COL_W-1:0]     wr_addr;
    logic [7:0]           wr_data;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = hold;
    assign accept      = i_valid && !hold;

    // stream control
    su_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_byte        (i_filtered_byte),
        .o_data_accept (data_accept),
        .o_tag         (tag),
        .o_bpp         (bpp),
        .o_bpp_idx     (bpp_idx)
    );

    // previous row, read at accept, written back from the datapath
    su_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (data_accept),
        .i_rd_addr (tag.col),
        .o_rd_data (above),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // reconstruction datapath
    su_recon u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (data_accept),
        .i_tag        (tag),
        .i_byte       (i_filtered_byte),
        .i_above      (above),
        .i_bpp        (bpp),
        .i_bpp_idx    (bpp_idx),
        .i_out_stall  (i_stall),
        .o_hold       (hold),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_valid      (o_valid),
        .o_pixel_byte (o_pixel_byte),
        .o_status     (o_status),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

endmodule

@@ hdl/su_checker.sv @@
// ----------------------------------------------------------------------------
// su_checker: port level checks of the scanline unfilter
// Watches the top level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module su_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_pixel_byte,
    input logic       o_status,
    input logic       o_row_end,
    input logic       o_image_end
);

    // no word left over from before a reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // input only backs up when the output word is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // bad filter type stays reported until reset
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |=> o_status)
        else $error("status cleared without reset");

    // a stalled word holds its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_byte)))
        else $error("stalled output word changed");

    // the last byte of an image is also the last byte of a row
    a_image_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_image_end) |-> o_row_end)
        else $error("image end without row end");

endmodule

bind scanline_unfilter su_checker u_su_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the scanline unfilter
// Drives a filtered byte stream with random gaps and output stalls, keeps its
// own model of the row reconstruction to predict every output word, and
// reprograms the row geometry while the block is idle, also within an image.
// ----------------------------------------------------------------------------
module tb_top
    import su_pkg::*;
();

    localparam int SETTLE_CYCLES = 4;       // pipeline depth plus margin
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 100;
    localparam logic [7:0] FLT_FIRST_BAD = 8'd5;

    typedef enum logic {ACT_BYTE, ACT_REG} t_act;

    // one reconstructed output word
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       status;
        logic       row_end;
        logic       image_end;
    } t_pixel;

    // one row of the directed script
    typedef struct packed {
        t_act                  act;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        t_pixel                want;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_filtered_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_pixel_byte;
    logic                  o_status;
    logic                  o_row_end;
    logic                  o_image_end;

    // typed expectation that travels with the word on the input
    logic   cur_typed;
    t_pixel cur_want;

    t_pixel pending_pixels [$];
    int     n_mismatch = 0;
    bit     hold_req = 1'b0;
    int     burst_left = 0;

    // model state
    logic [3:0]  bpp_reg;
    logic [13:0] rb_reg;
    logic [15:0] rows_reg;
    logic [7:0]  line_mem [MAX_ROW_BYTES];
    logic [7:0]  left_win [MAX_PIXEL_BYTES];
    logic [7:0]  upleft_win [MAX_PIXEL_BYTES];
    int          col_cnt;
    int          row_cnt;
    t_filter     cur_flt;
    bit          wait_type;
    bit          first_row_f;
    bit          err_f;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    scanline_unfilter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_filtered_byte (i_filtered_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_byte    (o_pixel_byte),
        .o_status        (o_status),
        .o_row_end       (o_row_end),
        .o_image_end     (o_image_end)
    );

    task automatic clear_model();
        bpp_reg     = 4'd1;
        rb_reg      = 14'd1;
        rows_reg    = 16'd1;
        col_cnt     = 0;
        row_cnt     = 0;
        cur_flt     = FLT_NONE;
        wait_type   = 1'b1;
        first_row_f = 1'b1;
        err_f       = 1'b0;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_win[i]   = 8'h00;
            upleft_win[i] = 8'h00;
        end
    endtask

    function automatic int row_len();
        int rb;
        rb = (rb_reg == 0) ? 1 : int'(rb_reg);
        return (rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb;
    endfunction

    // paeth: neighbour closest to left + above - upper-left, ties to left then above
    function automatic int paeth_choice(int a, int b, int c);
        int pa, pb, pc;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    // reconstruct one stream byte; type bytes only latch the filter
    task automatic reconstruct(input logic [7:0] x, output bit made, output t_pixel w);
        int bpp, rows, col, above, left, ul, pred;
        logic [7:0] recon;
        bit rend, iend;
        made = 1'b0;
        w    = '0;
        if (wait_type) begin
            if (x > 8'(FLT_PAETH)) begin
                err_f   = 1'b1;
                cur_flt = FLT_NONE;
            end else begin
                cur_flt = t_filter'(x[2:0]);
            end
            wait_type = 1'b0;
        end else begin
            bpp  = (bpp_reg == 0) ? 1 : int'(bpp_reg);
            bpp  = (bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp;
            rows = (rows_reg == 0) ? 1 : int'(rows_reg);
            col  = (col_cnt >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_cnt;

            above = first_row_f ? 0 : int'(line_mem[col]);
            if (col >= bpp) begin
                left = int'(left_win[bpp-1]);
                ul   = int'(upleft_win[bpp-1]);
            end else begin
                left = 0;
                ul   = 0;
            end

            case (cur_flt)
                FLT_SUB:   pred = left;
                FLT_UP:    pred = above;
                FLT_AVG:   pred = (left + above) / 2;
                FLT_PAETH: pred = paeth_choice(left, above, ul);
                default:   pred = 0;
            endcase
            recon = 8'(int'(x) + pred);

            line_mem[col] = recon;
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                left_win[i]   = left_win[i-1];
                upleft_win[i] = upleft_win[i-1];
            end
            left_win[0]   = recon;
            upleft_win[0] = 8'(above);

            // row and image bookkeeping
            rend = (col_cnt + 1) >= row_len();
            iend = 1'b0;
            if (rend) begin
                col_cnt     = 0;
                wait_type   = 1'b1;
                first_row_f = 1'b0;
                if (row_cnt + 1 >= rows) begin
                    iend        = 1'b1;
                    row_cnt     = 0;
                    first_row_f = 1'b1;
                end else begin
                    row_cnt = (row_cnt + 1) & 16'hFFFF;
                end
            end else begin
                col_cnt = (col_cnt + 1) & 16'h1FFF;
            end

            made = 1'b1;
            w    = '{pixel_byte: recon, status: err_f, row_end: rend, image_end: iend};
        end
    endtask

    // model update on accepted words and check of every output word
    always @(posedge i_clk) begin
        bit     made;
        t_pixel w;
        t_pixel exp_w;
        if (!i_rst_n) begin
            clear_model();
            pending_pixels.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BPP:  bpp_reg  = i_cfg_data[3:0];
                    REG_RB:   rb_reg   = i_cfg_data[13:0];
                    REG_ROWS: rows_reg = i_cfg_data[15:0];
                    default:  ;
                endcase
            end
            if (i_valid && !o_stall) begin
                reconstruct(i_filtered_byte, made, w);
                if (made)
                    pending_pixels.push_back(cur_typed ? cur_want : w);
            end
            if (o_valid && !i_stall) begin
                if (pending_pixels.size() == 0) begin
                    if (n_mismatch < REPORT_LIMIT)
                        $error("unexpected word: pixel_byte %0d", o_pixel_byte);
                    n_mismatch++;
                end else begin
                    exp_w = pending_pixels.pop_front();
                    if (o_pixel_byte !== exp_w.pixel_byte) begin
                        if (n_mismatch < REPORT_LIMIT)
                            $error("pixel_byte: expected %0d, got %0d",
                                   exp_w.pixel_byte, o_pixel_byte);
                        n_mismatch++;
                    end
                    if (o_status !== exp_w.status) begin
                        if (n_mismatch < REPORT_LIMIT)
                            $error("status: expected %0d, got %0d", exp_w.status, o_status);
                        n_mismatch++;
                    end
                    if (o_row_end !== exp_w.row_end) begin
                        if (n_mismatch < REPORT_LIMIT)
                            $error("row_end: expected %0d, got %0d",
                                   exp_w.row_end, o_row_end);
                        n_mismatch++;
                    end
                    if (o_image_end !== exp_w.image_end) begin
                        if (n_mismatch < REPORT_LIMIT)
                            $error("image_end: expected %0d, got %0d",
                                   exp_w.image_end, o_image_end);
                        n_mismatch++;
                    end
                end
            end
        end
    end

    // receiver: runs of stall and flow, rare free stretches, one long hold
    initial begin
        int  run_left;
        bit  run_stall;
        int  r;
        run_left  = 0;
        run_stall = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                run_stall = 1'b1;
                run_left  = HOLD_CYCLES;
            end else if (run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    run_stall = 1'b0;
                    run_left  = $urandom_range(50, 150);
                end else if (run_stall) begin
                    run_stall = 1'b0;
                    run_left  = $urandom_range(1, 8);
                end else begin
                    run_stall = 1'b1;
                    run_left  = (r < 15) ? $urandom_range(15, 40) : $urandom_range(1, 3);
                end
            end
            run_left--;
            i_stall <= run_stall;
        end
    end

    // sender gap: mostly none or short, a few long, sometimes a gap-free burst
    function automatic int sender_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end else if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // offer one stream word and hold it until accepted; entered at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic typed, input t_pixel want);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_filtered_byte <= b;
        cur_typed       <= typed;
        cur_want        <= want;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write; the first of a group waits for the block to drain
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit first, input bit last);
        if (first) begin
            i_valid <= 1'b0;
            while (pending_pixels.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic send_row(input logic [7:0] ftype);
        push_byte(ftype, 1'b0, '0);
        repeat (row_len())
            push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    function automatic t_step plain(input logic [7:0] b);
        return '{act: ACT_BYTE, reg_idx: '0, value: 16'(b), typed: 1'b0, want: '0};
    endfunction

    function automatic t_step known(input logic [7:0] b, input logic [7:0] px,
                                    input logic st, input logic re, input logic ie);
        return '{act: ACT_BYTE, reg_idx: '0, value: 16'(b), typed: 1'b1,
                 want: '{pixel_byte: px, status: st, row_end: re, image_end: ie}};
    endfunction

    function automatic t_step setreg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        return '{act: ACT_REG, reg_idx: idx, value: val, typed: 1'b0, want: '0};
    endfunction

    // stimulus
    initial begin
        t_step script [$];
        bit    first, last, at_start;
        int    n_random, phase, n_rows, r;
        logic [CFG_DATA_W-1:0] bpp_val, rb_val, rows_val;
        logic [7:0] ftype;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_BPP;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_filtered_byte = 8'h00;
        cur_typed       = 1'b0;
        cur_want        = '0;
        n_random        = 0;
        phase           = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        script = '{
            // reset geometry: one byte per row, one row per image
            plain(8'(FLT_NONE)), known(8'h00, 8'h00, 1'b0, 1'b1, 1'b1),
            // zero row length and zero row count act as one
            setreg(REG_RB, 16'd0), setreg(REG_ROWS, 16'd0),
            plain(8'(FLT_NONE)), known(8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1),
            // zero pixel size acts as one; sub on the first row, then up
            setreg(REG_BPP, 16'd0), setreg(REG_RB, 16'd3), setreg(REG_ROWS, 16'd2),
            plain(8'(FLT_SUB)), known(8'd10, 8'd10, 1'b0, 1'b0, 1'b0),
            known(8'd20, 8'd30, 1'b0, 1'b0, 1'b0), known(8'd250, 8'd24, 1'b0, 1'b1, 1'b0),
            plain(8'(FLT_UP)), known(8'd1, 8'd11, 1'b0, 1'b0, 1'b0),
            known(8'd2, 8'd32, 1'b0, 1'b0, 1'b0), known(8'd3, 8'd27, 1'b0, 1'b1, 1'b1),
            // average, then paeth cut short by a smaller row length mid-row
            setreg(REG_BPP, 16'd2), setreg(REG_RB, 16'd4), setreg(REG_ROWS, 16'd3),
            plain(8'(FLT_AVG)), plain(8'd100), plain(8'd100), plain(8'd100), plain(8'd100),
            plain(8'(FLT_PAETH)), plain(8'h80), plain(8'h7F),
            setreg(REG_BPP, 16'hFFFF), setreg(REG_RB, 16'd3),
            plain(8'h01),
            // bad filter type: row passes through, status sticks
            plain(FLT_FIRST_BAD), known(8'd5, 8'd5, 1'b1, 1'b0, 1'b0),
            known(8'd6, 8'd6, 1'b1, 1'b0, 1'b0), known(8'd7, 8'd7, 1'b1, 1'b1, 1'b1)
        };

        for (int i = 0; i < script.size(); i++) begin
            if (script[i].act == ACT_REG) begin
                first = (i == 0) || (script[i-1].act != ACT_REG);
                last  = (i == script.size() - 1) || (script[i+1].act != ACT_REG);
                cfg_write(script[i].reg_idx, script[i].value, first, last);
            end else begin
                push_byte(script[i].value[7:0], script[i].typed, script[i].want);
            end
        end

        // random phases of whole rows; row length only changes at an image start
        while (n_random < RANDOM_ITEMS) begin
            phase++;
            if (phase == 6)
                hold_req = 1'b1;
            at_start = wait_type && first_row_f && (row_cnt == 0);

            r = $urandom_range(0, 99);
            bpp_val = {12'($urandom), (r < 8) ? 4'd0 :
                       (r < 16) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8))};
            r = $urandom_range(0, 99);
            rows_val = (r < 10) ? 16'd0 : (r < 15) ? 16'hFFFF : 16'($urandom_range(1, 4));

            if ($urandom_range(0, 2) != 0) begin
                if (at_start) begin
                    r = $urandom_range(0, 99);
                    rb_val = {2'($urandom), (r < 8) ? 14'd0 :
                              (r < 18) ? 14'($urandom_range(25, 100)) :
                              14'($urandom_range(1, 24))};
                    cfg_write(REG_BPP, bpp_val, 1'b1, 1'b0);
                    cfg_write(REG_RB, rb_val, 1'b0, 1'b0);
                    cfg_write(REG_ROWS, rows_val, 1'b0, 1'b1);
                end else begin
                    cfg_write(REG_BPP, bpp_val, 1'b1, 1'b0);
                    cfg_write(REG_ROWS, rows_val, 1'b0, 1'b1);
                end
            end

            n_rows = $urandom_range(1, 5);
            repeat (n_rows) begin
                r = $urandom_range(0, 99);
                ftype = (r < 6) ? 8'($urandom_range(int'(FLT_FIRST_BAD), 255)) :
                        8'($urandom_range(0, 4));
                n_random += row_len() + 1;
                send_row(ftype);
            end
        end

        // drain and finish
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/su_pkg.sv
hdl/su_line_store.sv
hdl/su_ctrl.sv
hdl/su_recon.sv
hdl/scanline_unfilter.sv
hdl/su_checker.sv
tb/tb_top.sv
